[src/upn_pkg.sv]
// ----------------------------------------------------------------------------
// upn_pkg
// shared types and constants of the url path normalizer
// ----------------------------------------------------------------------------
package upn_pkg;

    localparam int COUNT_W         = 13;
    localparam int RES_MAX         = 4;
    localparam int RES_NUM_W       = $clog2(RES_MAX + 1);
    localparam int RES_IDX_W       = $clog2(RES_MAX);
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(1024);

    typedef logic [7:0] char_t;

    localparam char_t CHAR_SLASH  = 8'h2F;
    localparam char_t CHAR_BSLASH = 8'h5C;
    localparam char_t CHAR_DOT    = 8'h2E;
    localparam char_t CHAR_NUL    = 8'h00;

    // one command word: up to four result words for a single input word
    typedef struct packed {
        logic [RES_NUM_W-1:0]      num;
        char_t [RES_MAX-1:0]       chars;
        logic                      err;
        logic                      last;
    } cmd_t;

endpackage

[src/upn_front.sv]
// ----------------------------------------------------------------------------
// upn_front
// classifies each path word, tracks segment state and builds result commands
// ----------------------------------------------------------------------------
module upn_front
    import upn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  char_t              in_char,
    input  logic               has_char,
    input  logic               in_last,
    input  logic               push,
    output logic               full,
    input  logic [COUNT_W-1:0] limit,
    input  logic               q_full,
    output logic               enq,
    output cmd_t               enq_cmd
);

    logic               after_sep_reg, after_sep_next;
    logic               held_slash_reg, held_slash_next;
    logic [1:0]         held_dots_reg, held_dots_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               overflowed_reg, overflowed_next;

    logic               take;
    logic               is_sep;
    logic               is_dot;
    logic               case_a;
    logic               case_skip;
    logic               case_dot;
    logic               case_out;
    logic [1:0]         dots_eff;
    logic [1:0]         nd;
    logic               hs;
    logic [1:0]         nw;
    logic [COUNT_W-1:0] room;
    logic               pre_fail;
    logic               fail_take;
    logic               fail;
    logic [1:0]         n_counted;
    logic [RES_NUM_W-1:0] ncount;
    logic [COUNT_W-1:0] count_new;
    logic               held_new;
    logic               final_empty;
    logic               end_extra;

    assign full = q_full;
    assign take = push && !q_full;

    assign is_sep    = (in_char == CHAR_SLASH) || (in_char == CHAR_BSLASH);
    assign is_dot    = (in_char == CHAR_DOT);
    assign case_a    = has_char && !after_sep_reg && is_sep;
    assign case_skip = has_char && after_sep_reg && is_sep;
    assign case_dot  = has_char && after_sep_reg && is_dot && (held_dots_reg < 2'd2);
    assign case_out  = has_char && !case_a && !case_skip && !case_dot;

    assign dots_eff = (held_dots_reg == 2'd3) ? 2'd2 : held_dots_reg;
    assign nd       = (case_out && after_sep_reg) ? dots_eff : 2'd0;
    assign hs       = case_out && held_slash_reg;
    assign nw       = case_a ? 2'd1 : (case_out ? nd + 2'd1 : 2'd0);

    assign pre_fail  = count_reg >= limit;
    assign room      = limit - count_reg;
    assign fail_take = !pre_fail && (nw != 2'd0) && (room <= COUNT_W'(nw));
    assign fail      = pre_fail || fail_take;

    assign n_counted = fail_take ? (room[1:0] - 2'd1) : (case_out ? nw : 2'd0);
    assign ncount    = pre_fail ? '0 : (RES_NUM_W'(hs) + RES_NUM_W'(n_counted));

    assign count_new   = count_reg + COUNT_W'(nw);
    assign held_new    = case_a ? 1'b1 : (case_out ? 1'b0 : held_slash_reg);
    assign final_empty = (count_new == '0) || ((count_new == COUNT_W'(1)) && held_new);
    assign end_extra   = in_last && !fail && (ncount == '0);

    // result command for the current word
    always_comb
    begin
        logic [2:0] pos;
        pos = '0;
        enq_cmd = '0;
        enq_cmd.err  = fail;
        enq_cmd.last = in_last || fail;
        enq_cmd.num  = overflowed_reg ? '0
                     : ncount + RES_NUM_W'(fail) + RES_NUM_W'(end_extra);
        for (int i = 0; i < RES_MAX; i++)
        begin
            pos = 3'(i) - {2'b0, hs};
            if (RES_NUM_W'(i) == ncount && fail)
            begin
                enq_cmd.chars[i] = CHAR_NUL;
            end
            else if (RES_NUM_W'(i) == ncount && end_extra)
            begin
                enq_cmd.chars[i] = final_empty ? CHAR_SLASH : CHAR_NUL;
            end
            else if (i == 0 && hs)
            begin
                enq_cmd.chars[i] = CHAR_SLASH;
            end
            else if (pos < {1'b0, nd})
            begin
                enq_cmd.chars[i] = CHAR_DOT;
            end
            else
            begin
                enq_cmd.chars[i] = in_char;
            end
        end
    end

    assign enq = take && (enq_cmd.num != '0);

    // segment state update
    always_comb
    begin
        after_sep_next  = after_sep_reg;
        held_slash_next = held_slash_reg;
        held_dots_next  = held_dots_reg;
        count_next      = count_reg;
        overflowed_next = overflowed_reg;
        if (take)
        begin
            if (overflowed_reg || in_last)
            begin
                if (in_last)
                begin
                    after_sep_next  = 1'b0;
                    held_slash_next = 1'b0;
                    held_dots_next  = 2'd0;
                    count_next      = '0;
                    overflowed_next = 1'b0;
                end
            end
            else if (fail)
            begin
                overflowed_next = 1'b1;
            end
            else if (case_a)
            begin
                count_next      = count_new;
                held_slash_next = 1'b1;
                after_sep_next  = 1'b1;
            end
            else if (case_skip)
            begin
                held_dots_next = 2'd0;
            end
            else if (case_dot)
            begin
                held_dots_next = held_dots_reg + 2'd1;
            end
            else if (case_out)
            begin
                count_next      = count_new;
                held_slash_next = 1'b0;
                held_dots_next  = 2'd0;
                after_sep_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_sep_reg  <= 1'b0;
            held_slash_reg <= 1'b0;
            held_dots_reg  <= 2'd0;
            count_reg      <= '0;
            overflowed_reg <= 1'b0;
        end
        else
        begin
            after_sep_reg  <= after_sep_next;
            held_slash_reg <= held_slash_next;
            held_dots_reg  <= held_dots_next;
            count_reg      <= count_next;
            overflowed_reg <= overflowed_next;
        end
    end

endmodule

[src/upn_queue.sv]
// ----------------------------------------------------------------------------
// upn_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module upn_queue
    import upn_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic q_full,
    input  logic rd_en,
    output logic q_valid,
    output cmd_t rd_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign rd_cmd  = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[src/upn_back.sv]
// ----------------------------------------------------------------------------
// upn_back
// walks each command and hands out its result words one per cycle while pop is held
// ----------------------------------------------------------------------------
module upn_back
    import upn_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_valid,
    input  cmd_t  q_cmd,
    output logic  q_rd,
    output logic  empty,
    input  logic  pop,
    output char_t out_char,
    output logic  is_error,
    output logic  out_last
);

    cmd_t                 cur_reg, cur_next;
    logic [RES_IDX_W-1:0] idx_reg, idx_next;
    logic                 busy_reg, busy_next;
    logic                 last_entry;
    logic                 finish;

    assign last_entry = (RES_NUM_W'(idx_reg) == cur_reg.num - RES_NUM_W'(1));
    assign finish     = busy_reg && pop && last_entry;
    assign q_rd       = q_valid && (!busy_reg || finish);

    assign empty    = !busy_reg;
    assign out_char = cur_reg.chars[idx_reg];
    assign is_error = cur_reg.err && last_entry;
    assign out_last = cur_reg.last && last_entry;

    always_comb
    begin
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (q_rd)
        begin
            cur_next  = q_cmd;
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && pop)
        begin
            idx_next = idx_reg + RES_IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

endmodule

[src/url_path_normalizer.sv]
// ----------------------------------------------------------------------------
// url_path_normalizer
// streaming url path normalizer, one path byte in per word
// ----------------------------------------------------------------------------
// Accepts one path word per clock while the internal command queue has room
// (QUEUE_DEPTH commands). Each input word turns into zero to four result words,
// which the back part hands out one per clock while pop is held, so the output
// sustains one result word per cycle while popped; an input word that expands
// into n results holds the output for those n words while the input keeps
// flowing until the queue fills. Results pass through the queue and then the
// back part's command register. length_limit is written through the cfg
// channel, which is always ready, and should be changed only between paths.
// ----------------------------------------------------------------------------
module url_path_normalizer
    import upn_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         in_char,
    input  logic               has_char,
    input  logic               in_last,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         out_char,
    output logic               is_error,
    output logic               out_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    logic [COUNT_W-1:0] length_limit_reg, length_limit_next;
    logic               enq;
    cmd_t               enq_cmd;
    logic               q_full;
    logic               q_valid;
    logic               q_rd;
    cmd_t               q_cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        length_limit_next = length_limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            length_limit_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_limit_reg <= LIMIT_RESET;
        end
        else
        begin
            length_limit_reg <= length_limit_next;
        end
    end

    upn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_char  (in_char),
        .has_char (has_char),
        .in_last  (in_last),
        .push     (push),
        .full     (full),
        .limit    (length_limit_reg),
        .q_full   (q_full),
        .enq      (enq),
        .enq_cmd  (enq_cmd)
    );

    upn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (enq),
        .wr_cmd  (enq_cmd),
        .q_full  (q_full),
        .rd_en   (q_rd),
        .q_valid (q_valid),
        .rd_cmd  (q_cmd)
    );

    upn_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_rd     (q_rd),
        .empty    (empty),
        .pop      (pop),
        .out_char (out_char),
        .is_error (is_error),
        .out_last (out_last)
    );

endmodule

[src/upn_props.sv]
// ----------------------------------------------------------------------------
// upn_props
// port level checks for the url path normalizer
// ----------------------------------------------------------------------------
module upn_props
    import upn_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic [7:0]         in_char,
    input logic               has_char,
    input logic               in_last,
    input logic               empty,
    input logic               pop,
    input logic [7:0]         out_char,
    input logic               is_error,
    input logic               out_last,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [COUNT_W-1:0] cfg_data
);

    // an error word always closes its path
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_error) |-> out_last)
        else $error("error word without last mark");

    // an error word carries no character
    a_err_nul: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_error) |-> (out_char == CHAR_NUL))
        else $error("error word with nonzero character");

    // backslashes never leave the block
    a_no_bslash: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_char != CHAR_BSLASH))
        else $error("backslash in normalized output");

    // a waiting word holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(is_error)
                              && $stable(out_last)))
        else $error("waiting result word changed");

endmodule

bind url_path_normalizer upn_props u_props (.*);
